[sv/bbs_pkg.sv]
// Shared types, constants and helpers for the bicubic Bezier surface evaluator.
`default_nettype none
package bbs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int C_W       = 24;
  localparam int PARAM_W   = 17;
  localparam int STEP_W    = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int PROD_W    = C_W + T_W + 2;
  localparam int NPTS      = 16;
  localparam int PIDX_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PROD_W-1:0] LERP_HALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EVAL = 2'd1;
  localparam logic [1:0] OP_ANIM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd2;

  typedef logic signed [C_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;  // lane 0 x, lane 1 y, lane 2 z

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         point_row;
    logic [1:0]         point_col;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [16:0]        param_u;
    logic [16:0]        param_v;
  } bbs_in_t;

  typedef struct packed {
    logic signed [23:0] surf_x;
    logic signed [23:0] surf_y;
    logic signed [23:0] surf_z;
  } bbs_out_t;

  // one lerp slot: issue into the unit, or write-back out of it
  typedef struct packed {
    logic       vld;
    logic [1:0] dst;
  } bbs_slot_t;

  typedef struct packed {
    logic              load;
    logic              anim;
    logic [PIDX_W-1:0] idx;
  } bbs_gcmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    coord_t            high;
    coord_t            low;
  } bbs_bounce_t;

  localparam int CMP_W = (T_W > PARAM_W) ? T_W : PARAM_W;

  function automatic logic [T_W-1:0] sat_param(input logic [PARAM_W-1:0] p);
    logic [CMP_W-1:0] pe;
    pe = CMP_W'(p);
    if (pe > CMP_W'(T_ONE)) return T_ONE;
    return T_W'(pe);
  endfunction

endpackage
`default_nettype wire

[sv/bbs_lerp.sv]
// Shared three-lane lerp unit; the issue slot, the product and operand a are registered once before write-back.
`default_nettype none
module bbs_lerp (
  input  logic              clk,
  input  logic              rst_n,
  input  bbs_pkg::bbs_slot_t iss,
  input  bbs_pkg::vec_t     a,
  input  bbs_pkg::vec_t     b,
  input  logic [bbs_pkg::T_W-1:0] t,
  output bbs_pkg::bbs_slot_t wb,
  output bbs_pkg::vec_t     res
);
  import bbs_pkg::*;

  bbs_slot_t wb_r;
  vec_t      a_r;
  logic signed [T_W:0] t_s;

  assign t_s = $signed({1'b0, t});
  assign wb  = wb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= '0;
    end else begin
      wb_r <= iss;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [C_W:0]     diff;
    logic signed [PROD_W-1:0] prod_nxt;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] sh;

    // a*(1-t) + b*t == a*ONE + (b-a)*t, so only the difference is multiplied
    assign diff     = $signed({b[l][C_W-1], b[l]}) - $signed({a[l][C_W-1], a[l]});
    assign prod_nxt = diff * t_s;

    always_ff @(posedge clk) begin
      prod_r <= prod_nxt;
    end

    // round half up, floor shift; the result is a convex mix and fits C_W
    assign sum    = prod_r + LERP_HALF;
    assign sh     = sum >>> FRAC_BITS;
    assign res[l] = a_r[l] + sh[C_W-1:0];
  end

endmodule
`default_nettype wire

[sv/bbs_grid.sv]
// Control point store with its load write and the per-point bounce update.
`default_nettype none
module bbs_grid (
  input  logic                clk,
  input  logic                rst_n,
  input  bbs_pkg::bbs_gcmd_t  cmd,
  input  bbs_pkg::vec_t       wr_pt,
  input  bbs_pkg::bbs_bounce_t bnc,
  output bbs_pkg::vec_t       rd_pt
);
  import bbs_pkg::*;

  localparam int ZW = C_W + 2;
  localparam logic [NPTS-1:0] RISE_RST = {{(NPTS/2){1'b0}}, {(NPTS/2){1'b1}}};

  coord_t x_r [NPTS];
  coord_t y_r [NPTS];
  coord_t z_r [NPTS];
  logic [NPTS-1:0] rise_r;

  coord_t z_cur;
  logic   rise_nxt;
  logic signed [ZW-1:0] z_ext;
  logic signed [ZW-1:0] s_ext;
  logic signed [ZW-1:0] z_sum;
  coord_t z_nxt;

  assign rd_pt[0] = x_r[cmd.idx];
  assign rd_pt[1] = y_r[cmd.idx];
  assign rd_pt[2] = z_r[cmd.idx];
  assign z_cur    = z_r[cmd.idx];

  always_comb begin
    // low bound wins when both hold
    if (z_cur <= bnc.low) begin
      rise_nxt = 1'b1;
    end else if (z_cur >= bnc.high) begin
      rise_nxt = 1'b0;
    end else begin
      rise_nxt = rise_r[cmd.idx];
    end
    z_ext = ZW'(z_cur);
    s_ext = ZW'($signed({1'b0, bnc.step}));
    z_sum = rise_nxt ? (z_ext + s_ext) : (z_ext - s_ext);
    if (z_sum[ZW-1:C_W-1] == '0 || z_sum[ZW-1:C_W-1] == '1) begin
      z_nxt = z_sum[C_W-1:0];
    end else if (z_sum[ZW-1]) begin
      z_nxt = {1'b1, {(C_W-1){1'b0}}};
    end else begin
      z_nxt = {1'b0, {(C_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NPTS; i++) begin
        x_r[i] <= '0;
        y_r[i] <= '0;
        z_r[i] <= '0;
      end
      rise_r <= RISE_RST;
    end else if (cmd.load) begin
      x_r[cmd.idx]    <= wr_pt[0];
      y_r[cmd.idx]    <= wr_pt[1];
      z_r[cmd.idx]    <= wr_pt[2];
      rise_r[cmd.idx] <= ~cmd.idx[PIDX_W-1];
    end else if (cmd.anim) begin
      z_r[cmd.idx]    <= z_nxt;
      rise_r[cmd.idx] <= rise_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/bicubic_bezier_surface_eval_unit.sv]
// Top level: sequencer, working registers, configuration and result register.
//
//   channel | direction | handshake               | payload
//   in_     | in        | in_valid / in_ready     | bbs_in_t (op, point, u, v)
//   out_    | out       | out_valid / out_ready   | bbs_out_t (surf_x/y/z)
//   cfg_    | in        | cfg_wr_en, no wait      | cfg_idx, cfg_wdata
//
// A load is written by the grid as it is taken; an animate walks the grid,
// one control point per cycle. An evaluate runs, per row, four point fetches
// and an eight-step de Casteljau cubic, then one more cubic across the rows;
// the registered lerp write-back and the dependence between levels shape it.
// Reset is synchronous and active low; it clears the grid to zero and sets
// rising for rows 0 and 1. in_ready is high only while the sequencer idles.
// A finished result waits in the output register; new beats are taken meanwhile.
`default_nettype none
module bicubic_bezier_surface_eval_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bbs_pkg::bbs_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bbs_pkg::bbs_out_t                  out_data,
  input  logic                               cfg_wr_en,
  input  logic [bbs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bbs_pkg::CFG_W-1:0]          cfg_wdata
);
  import bbs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_CUBIC = 3'd2;
  localparam logic [2:0] ST_ANIM  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [2:0] STEP_LAST = 3'd7;

  // sequencer
  logic [2:0]        state_r, state_nxt;
  logic [PIDX_W-1:0] idx_r, idx_nxt;     // {row, col}
  logic [2:0]        step_r, step_nxt;
  logic              final_r, final_nxt; // cubic across the rows, in v
  logic [T_W-1:0]    u_r, u_nxt;
  logic [T_W-1:0]    v_r, v_nxt;

  // working points and row results
  vec_t p_r    [4];
  vec_t p_nxt  [4];
  vec_t rowv_r [3];
  vec_t rowv_nxt [3];

  // result register
  logic     out_valid_r, out_valid_nxt;
  bbs_out_t out_data_r, out_data_nxt;

  // configuration
  logic [STEP_W-1:0] step_cfg_r;
  coord_t            high_r;
  coord_t            low_r;

  logic        accept;
  logic        cubic_end;
  logic [1:0]  src;
  bbs_slot_t   iss;
  bbs_slot_t   wb;
  vec_t        op_a, op_b, lerp_res;
  vec_t        grid_rd, wr_pt;
  bbs_gcmd_t   gcmd;
  bbs_bounce_t bnc;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cubic_end = (state_r == ST_CUBIC) && (step_r == STEP_LAST);

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cfg_r <= STEP_W'(655);
      high_r     <= C_W'(65536);
      low_r      <= -C_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        CFG_STEP: step_cfg_r <= cfg_wdata[STEP_W-1:0];
        CFG_HIGH: high_r     <= cfg_wdata[C_W-1:0];
        CFG_LOW:  low_r      <= cfg_wdata[C_W-1:0];
        default:  ;
      endcase
    end
  end

  assign bnc.step = step_cfg_r;
  assign bnc.high = high_r;
  assign bnc.low  = low_r;

  // The grid sees one address: the incoming beat's point while idle,
  // otherwise the sequencer's walk.
  always_comb begin
    gcmd.load = accept && (in_data.op == OP_LOAD);
    gcmd.anim = (state_r == ST_ANIM);
    gcmd.idx  = in_ready ? {in_data.point_row, in_data.point_col} : idx_r;
  end

  assign wr_pt[0] = in_data.point_x;
  assign wr_pt[1] = in_data.point_y;
  assign wr_pt[2] = in_data.point_z;

  bbs_grid u_grid (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (gcmd),
    .wr_pt (wr_pt),
    .bnc   (bnc),
    .rd_pt (grid_rd)
  );

  // Cubic schedule: three first-level lerps, two second-level, one last.
  // Each pair (i, i+1) overwrites entry i in place; a bubble at step 5
  // waits for the second-level result to land.
  always_comb begin
    iss.vld = 1'b0;
    src     = 2'd0;
    if (state_r == ST_CUBIC) begin
      unique case (step_r)
        3'd0: begin iss.vld = 1'b1; src = 2'd0; end
        3'd1: begin iss.vld = 1'b1; src = 2'd1; end
        3'd2: begin iss.vld = 1'b1; src = 2'd2; end
        3'd3: begin iss.vld = 1'b1; src = 2'd0; end
        3'd4: begin iss.vld = 1'b1; src = 2'd1; end
        3'd6: begin iss.vld = 1'b1; src = 2'd0; end
        default: ;
      endcase
    end
    iss.dst = src;
    unique case (src)
      2'd0:    begin op_a = p_r[0]; op_b = p_r[1]; end
      2'd1:    begin op_a = p_r[1]; op_b = p_r[2]; end
      default: begin op_a = p_r[2]; op_b = p_r[3]; end
    endcase
  end

  bbs_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .iss   (iss),
    .a     (op_a),
    .b     (op_b),
    .t     (final_r ? v_r : u_r),
    .wb    (wb),
    .res   (lerp_res)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    final_nxt     = final_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    for (int i = 0; i < 4; i++) p_nxt[i] = p_r[i];
    for (int i = 0; i < 3; i++) rowv_nxt[i] = rowv_r[i];

    // write-back from the lerp unit
    if (wb.vld) begin
      p_nxt[wb.dst] = lerp_res;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_data.op == OP_EVAL) begin
            u_nxt     = sat_param(in_data.param_u);
            v_nxt     = sat_param(in_data.param_v);
            idx_nxt   = '0;
            final_nxt = 1'b0;
            state_nxt = ST_FETCH;
          end else if (in_data.op == OP_ANIM) begin
            idx_nxt   = '0;
            state_nxt = ST_ANIM;
          end else begin
            // load is done by the grid in this cycle; unused op is dropped
          end
        end
      end
      ST_FETCH: begin
        p_nxt[idx_r[1:0]] = grid_rd;
        idx_nxt[1:0]      = idx_r[1:0] + 2'd1;
        if (idx_r[1:0] == 2'd3) begin
          step_nxt  = '0;
          state_nxt = ST_CUBIC;
        end
      end
      ST_CUBIC: begin
        step_nxt = step_r + 3'd1;
        if (cubic_end) begin
          if (final_r) begin
            state_nxt = ST_DONE;
          end else if (idx_r[3:2] == 2'd3) begin
            // last row done: seed the cubic in v with all four row results
            for (int i = 0; i < 3; i++) p_nxt[i] = rowv_r[i];
            p_nxt[3]  = lerp_res;
            final_nxt = 1'b1;
            step_nxt  = '0;
          end else begin
            rowv_nxt[idx_r[3:2]] = lerp_res;
            idx_nxt              = {idx_r[3:2] + 2'd1, 2'd0};
            state_nxt            = ST_FETCH;
          end
        end
      end
      ST_ANIM: begin
        idx_nxt = idx_r + PIDX_W'(1);
        if (idx_r == PIDX_W'(NPTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.surf_x = p_r[0][0];
          out_data_nxt.surf_y = p_r[0][1];
          out_data_nxt.surf_z = p_r[0][2];
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      step_r      <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < 4; i++) p_r[i] <= p_nxt[i];
    for (int i = 0; i < 3; i++) rowv_r[i] <= rowv_nxt[i];
  end

endmodule
`default_nettype wire

[sv/bbs_checker.sv]
// Port-level checks for the surface evaluator, bound to the top level.
`default_nettype none
module bbs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input bbs_pkg::bbs_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input bbs_pkg::bbs_out_t             out_data
);
  import bbs_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // evaluate and animate occupy the sequencer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.op == OP_EVAL || in_data.op == OP_ANIM) |=> !in_ready)
    else $error("ready after a multi-cycle beat");

  // a load completes in its own cycle
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.op == OP_LOAD |=> in_ready)
    else $error("load held the input");

  // a result appears just as the sequencer returns to idle
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset state wrong");

endmodule

bind bicubic_bezier_surface_eval_unit bbs_checker u_bbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
